// File: sv/wkm_pkg.sv
// Shared constants, codes, types and helpers of the weighted k-slot mutex node.
package wkm_pkg;

  // Sizing of the peer table and the fields
  localparam int MAX_NODES  = 16;
  localparam int IDX_W      = $clog2(MAX_NODES);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int PEER_W     = 4;
  localparam int NODE_W     = 5;
  localparam int SLOT_W     = 5;
  localparam int CAP_W      = 8;
  localparam int AMT_W      = 8;
  localparam int STAMP_W    = 32;
  localparam int ACC_W      = AMT_W + IDX_W;
  localparam int SUM_W      = ACC_W + 1;
  localparam int OP_W       = 2;
  localparam int KIND_W     = 2;
  localparam int CLS_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Event operations
  localparam logic [OP_W-1:0] OP_PEER_REQ = 2'd0;
  localparam logic [OP_W-1:0] OP_PEER_ACK = 2'd1;
  localparam logic [OP_W-1:0] OP_START    = 2'd2;
  localparam logic [OP_W-1:0] OP_RELEASE  = 2'd3;

  // Peer classes
  localparam logic [CLS_W-1:0] CLS_UNKNOWN = 2'd0;
  localparam logic [CLS_W-1:0] CLS_AHEAD   = 2'd1;
  localparam logic [CLS_W-1:0] CLS_DEFER   = 2'd2;
  localparam logic [CLS_W-1:0] CLS_NEUTRAL = 2'd3;

  // Outgoing message kinds
  localparam logic [KIND_W-1:0] MSG_NONE = 2'd0;
  localparam logic [KIND_W-1:0] MSG_REQ  = 2'd1;
  localparam logic [KIND_W-1:0] MSG_ACK  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd3;

  // Control of the grant accumulator
  typedef struct packed {
    logic             clear;
    logic             add;
    logic [AMT_W-1:0] need;
  } acc_ctl_t;

  // Saturating increment of the Lamport clock
  function automatic logic [STAMP_W-1:0] sat_inc(input logic [STAMP_W-1:0] x);
    logic [STAMP_W-1:0] r;
    r = (x == {STAMP_W{1'b1}}) ? x : x + 1'b1;
    return r;
  endfunction

  // Number of nodes in effect
  function automatic logic [CNT_W-1:0] node_limit(input logic [NODE_W-1:0] cnt);
    logic [CNT_W-1:0] r;
    if (int'(cnt) > MAX_NODES || int'(cnt) > 16) begin
      r = (MAX_NODES < 16) ? CNT_W'(MAX_NODES) : CNT_W'(16);
    end else begin
      r = CNT_W'(cnt);
    end
    return r;
  endfunction

endpackage

// File: sv/wkm_if.sv
// Channel interfaces of the mutex node: event input, message output, configuration writes.
interface wkm_evt_if;
  import wkm_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [PEER_W-1:0]   peer_id;
  logic [STAMP_W-1:0]  peer_stamp;
  logic [AMT_W-1:0]    peer_amount;
  logic [STAMP_W-1:0]  peer_clock;
  logic [AMT_W-1:0]    own_amount;
  modport source (output valid, op, peer_id, peer_stamp, peer_amount, peer_clock,
                  own_amount, input ready);
  modport sink   (input valid, op, peer_id, peer_stamp, peer_amount, peer_clock,
                  own_amount, output ready);
endinterface

interface wkm_msg_if;
  import wkm_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   msg_kind;
  logic [PEER_W-1:0]   dest_id;
  logic [STAMP_W-1:0]  msg_stamp;
  logic [AMT_W-1:0]    msg_amount;
  logic [STAMP_W-1:0]  msg_clock;
  logic                granted;
  logic                last;
  modport source (output valid, msg_kind, dest_id, msg_stamp, msg_amount, msg_clock,
                  granted, last, input ready);
  modport sink   (input valid, msg_kind, dest_id, msg_stamp, msg_amount, msg_clock,
                  granted, last, output ready);
endinterface

interface wkm_cfg_if;
  import wkm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/weighted_k_mutex_node.sv
// Steps: the update (S_EXEC) and the clock merge (S_MERGE); while a request is open and
// not held, the grant scan over up to 16 peer entries, one per cycle through the accumulator
// (S_SCAN), and the grant decision (S_DECIDE); then the walk over the peer indexes that
// emits the results (S_EMIT). A new request is taken only in S_IDLE, once the last result
// of the previous one is loaded. Results leave through one output register, one per cycle
// while the sink is ready and no index is walked past. Reset (rst, synchronous): clock, flags,
// peer classes and config return to defaults; the peer stamp and amount table is not cleared.
module weighted_k_mutex_node (
  input  logic      clk,
  input  logic      rst,
  wkm_cfg_if.sink   cfg,
  wkm_evt_if.sink   evt,
  wkm_msg_if.source msg
);
  import wkm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_MERGE  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]          state;

  // Configuration
  logic [PEER_W-1:0]   own_id;
  logic [NODE_W-1:0]   node_count;
  logic [SLOT_W-1:0]   slot_count;
  logic [CAP_W-1:0]    capacity_total;

  // Node state
  logic [STAMP_W-1:0]  lamport_clock;
  logic [STAMP_W-1:0]  own_stamp;
  logic [AMT_W-1:0]    own_need;
  logic                is_requesting;
  logic                is_holding;
  logic [CLS_W-1:0]    peer_class [MAX_NODES];
  logic [STAMP_W-1:0]  peer_req_stamp [MAX_NODES];
  logic [AMT_W-1:0]    peer_need [MAX_NODES];

  // Held request
  logic [OP_W-1:0]     op_r;
  logic [PEER_W-1:0]   pid_r;
  logic [STAMP_W-1:0]  pstamp_r;
  logic [AMT_W-1:0]    pamount_r;
  logic [STAMP_W-1:0]  pclock_r;
  logic [AMT_W-1:0]    oamount_r;

  // Sequencer working registers
  logic                merge_en;
  logic [STAMP_W-1:0]  merge_val;
  logic [MAX_NODES-1:0] send_mask;
  logic [KIND_W-1:0]   send_kind;
  logic [STAMP_W-1:0]  msg_clk;
  logic [IDX_W-1:0]    idx;

  // Output register
  logic                out_valid;
  logic [KIND_W-1:0]   out_kind;
  logic [PEER_W-1:0]   out_dest;
  logic [STAMP_W-1:0]  out_stamp;
  logic [AMT_W-1:0]    out_amount;
  logic [STAMP_W-1:0]  out_clock;
  logic                out_granted;
  logic                out_last;

  // Combinational helpers
  logic [CNT_W-1:0]    n_eff;
  logic [IDX_W-1:0]    pidx;
  logic                peer_ok;
  logic                we_win;
  logic [STAMP_W-1:0]  tick_val;
  logic [STAMP_W-1:0]  merge_next;
  logic [CLS_W-1:0]    ack_cls;
  logic                idx_in_range;
  logic                load_ok;
  logic                out_load;
  logic [MAX_NODES-1:0] idx_bit;
  logic [MAX_NODES-1:0] mask_next;
  logic [IDX_W-1:0]    idx_next;
  logic [MAX_NODES-1:0] start_mask;
  logic [MAX_NODES-1:0] release_mask;
  logic                fits;
  acc_ctl_t            acc_ctl;

  assign cfg.ready = 1'b1;
  assign evt.ready = (state == S_IDLE);

  assign msg.valid      = out_valid;
  assign msg.msg_kind   = out_kind;
  assign msg.dest_id    = out_dest;
  assign msg.msg_stamp  = out_stamp;
  assign msg.msg_amount = out_amount;
  assign msg.msg_clock  = out_clock;
  assign msg.granted    = out_granted;
  assign msg.last       = out_last;

  always_comb begin
    n_eff    = node_limit(node_count);
    pidx     = IDX_W'(pid_r);
    peer_ok  = (int'(pid_r) < int'(n_eff)) && (pid_r != own_id);
    if (own_stamp == pstamp_r) begin
      we_win = is_requesting && (own_id < pid_r);
    end else begin
      we_win = is_requesting && (own_stamp < pstamp_r);
    end
    tick_val   = sat_inc(lamport_clock);
    merge_next = sat_inc((merge_val > lamport_clock) ? merge_val : lamport_clock);
    // Ack drops an ahead or neutral peer back to unknown
    ack_cls = peer_class[pidx];
    if (ack_cls == CLS_AHEAD || ack_cls == CLS_NEUTRAL) begin
      ack_cls = CLS_UNKNOWN;
    end
    idx_in_range = (int'(idx) < int'(n_eff)) && (int'(idx) != int'(own_id));
    load_ok  = !out_valid || msg.ready;
    out_load = (state == S_EMIT) && load_ok && ((send_mask == '0) || send_mask[idx]);
    idx_bit  = MAX_NODES'(1) << idx;
    mask_next = send_mask & ~idx_bit;
    idx_next = (int'(idx) == MAX_NODES - 1) ? '0 : idx + 1'b1;
    for (int i = 0; i < MAX_NODES; i++) begin
      start_mask[i]   = (i < int'(n_eff)) && (i != int'(own_id));
      release_mask[i] = start_mask[i] && (peer_class[i] == CLS_DEFER);
    end
    acc_ctl.clear = (state == S_MERGE);
    acc_ctl.add   = (state == S_SCAN) && idx_in_range && (peer_class[idx] == CLS_AHEAD);
    acc_ctl.need  = peer_need[idx];
  end

  wkm_grant_acc u_acc (
    .clk            (clk),
    .rst            (rst),
    .ctl            (acc_ctl),
    .own_need       (own_need),
    .slot_count     (slot_count),
    .capacity_total (capacity_total),
    .fits           (fits)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      own_id         <= '0;
      node_count     <= NODE_W'(2);
      slot_count     <= SLOT_W'(1);
      capacity_total <= CAP_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_OWN_ID:     own_id         <= cfg.data[PEER_W-1:0];
        CFG_NODE_COUNT: node_count     <= cfg.data[NODE_W-1:0];
        CFG_SLOT_COUNT: slot_count     <= cfg.data[SLOT_W-1:0];
        CFG_CAPACITY:   capacity_total <= cfg.data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      op_r      <= evt.op;
      pid_r     <= evt.peer_id;
      pstamp_r  <= evt.peer_stamp;
      pamount_r <= evt.peer_amount;
      pclock_r  <= evt.peer_clock;
      oamount_r <= evt.own_amount;
    end
  end

  // Store peer stamp and amount on peer request or matching ack
  always_ff @(posedge clk) begin
    if (state == S_EXEC && peer_ok) begin
      if (op_r == OP_PEER_REQ ||
          (op_r == OP_PEER_ACK && pstamp_r == own_stamp && ack_cls != CLS_DEFER)) begin
        peer_req_stamp[pidx] <= pstamp_r;
        peer_need[pidx]      <= pamount_r;
      end
    end
  end

  // Sequencer: update, merge clock, grant scan, emit results
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      lamport_clock <= '0;
      own_stamp     <= '0;
      own_need      <= '0;
      is_requesting <= 1'b0;
      is_holding    <= 1'b0;
      out_valid     <= 1'b0;
      send_mask     <= '0;
      idx           <= '0;
      merge_en      <= 1'b0;
      for (int i = 0; i < MAX_NODES; i++) begin
        peer_class[i] <= CLS_UNKNOWN;
      end
    end else begin
      // Load a new result, or drop a taken one
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (msg.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (evt.valid) begin
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          msg_clk <= tick_val;
          case (op_r)
            OP_PEER_REQ: begin
              send_kind <= MSG_ACK;
              merge_en  <= peer_ok;
              merge_val <= pstamp_r;
              if (peer_ok && !we_win) begin
                lamport_clock    <= tick_val;
                peer_class[pidx] <= CLS_AHEAD;
                send_mask        <= MAX_NODES'(1) << pidx;
              end else begin
                if (peer_ok) begin
                  peer_class[pidx] <= CLS_DEFER;
                end
                send_mask <= '0;
              end
            end
            OP_PEER_ACK: begin
              send_mask <= '0;
              merge_en  <= peer_ok && (pstamp_r == own_stamp);
              merge_val <= pclock_r;
              if (peer_ok) begin
                // A current ack marks the peer neutral unless we defer it
                if (pstamp_r == own_stamp && ack_cls != CLS_DEFER) begin
                  peer_class[pidx] <= CLS_NEUTRAL;
                end else begin
                  peer_class[pidx] <= ack_cls;
                end
              end
            end
            OP_START: begin
              merge_en  <= 1'b0;
              send_kind <= MSG_REQ;
              if (!is_requesting) begin
                lamport_clock <= tick_val;
                own_stamp     <= tick_val;
                own_need      <= oamount_r;
                send_mask     <= start_mask;
                is_requesting <= 1'b1;
              end else begin
                send_mask <= '0;
              end
            end
            OP_RELEASE: begin
              merge_en  <= 1'b0;
              send_kind <= MSG_ACK;
              if (is_holding) begin
                lamport_clock <= tick_val;
                send_mask     <= release_mask;
                for (int i = 0; i < MAX_NODES; i++) begin
                  if (i < int'(n_eff)) begin
                    if (peer_class[i] == CLS_NEUTRAL) begin
                      peer_class[i] <= CLS_UNKNOWN;
                    end else if (peer_class[i] == CLS_DEFER) begin
                      peer_class[i] <= CLS_AHEAD;
                    end
                  end
                end
                is_requesting <= 1'b0;
                is_holding    <= 1'b0;
              end else begin
                send_mask <= '0;
              end
            end
            default: begin
              merge_en  <= 1'b0;
              send_mask <= '0;
            end
          endcase
          state <= S_MERGE;
        end

        S_MERGE: begin
          if (merge_en) begin
            lamport_clock <= merge_next;
          end
          idx   <= '0;
          state <= (is_requesting && !is_holding) ? S_SCAN : S_EMIT;
        end

        S_SCAN: begin
          // Any unclassified peer blocks the grant
          if (idx_in_range && peer_class[idx] == CLS_UNKNOWN) begin
            idx   <= '0;
            state <= S_EMIT;
          end else if (int'(idx) == MAX_NODES - 1) begin
            idx   <= '0;
            state <= S_DECIDE;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_DECIDE: begin
          if (fits) begin
            is_holding <= 1'b1;
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (send_mask == '0) begin
            // No message: one empty result
            if (load_ok) begin
              out_kind    <= MSG_NONE;
              out_dest    <= '0;
              out_stamp   <= '0;
              out_amount  <= '0;
              out_clock   <= '0;
              out_granted <= is_holding;
              out_last    <= 1'b1;
              state       <= S_IDLE;
            end
          end else if (send_mask[idx]) begin
            if (load_ok) begin
              out_kind    <= send_kind;
              out_dest    <= PEER_W'(idx);
              out_clock   <= msg_clk;
              out_granted <= is_holding;
              if (send_kind == MSG_REQ) begin
                out_stamp  <= own_stamp;
                out_amount <= own_need;
              end else begin
                out_stamp  <= peer_req_stamp[idx];
                out_amount <= peer_need[idx];
              end
              out_last  <= (mask_next == '0);
              send_mask <= mask_next;
              idx       <= idx_next;
              if (mask_next == '0) begin
                state <= S_IDLE;
              end
            end
          end else begin
            idx <= idx_next;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Holding always implies an open request
  a_hold_req: assert property (@(posedge clk) disable iff (rst)
    is_holding |-> is_requesting)
    else $error("holding without an open request");

  // An accepted request starts the update step
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && evt.ready) |=> (state == S_EXEC))
    else $error("accepted request did not start processing");

  // The Lamport clock never moves backward outside reset
  a_clock_mono: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && lamport_clock != $past(lamport_clock)) |->
      (lamport_clock > $past(lamport_clock)))
    else $error("Lamport clock moved backward");

  // An empty result is always the only and last one
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == MSG_NONE) |-> out_last)
    else $error("empty result not marked last");

  // Results are loaded only in the emit step
  a_emit_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> ($past(state) == S_EMIT))
    else $error("result loaded outside the emit step");

endmodule

// File: sv/wkm_grant_acc.sv
// Grant accumulator: counts ahead peers and sums their amounts, one entry per cycle.
module wkm_grant_acc (
  input  logic                     clk,
  input  logic                     rst,
  input  wkm_pkg::acc_ctl_t        ctl,
  input  logic [wkm_pkg::AMT_W-1:0]  own_need,
  input  logic [wkm_pkg::SLOT_W-1:0] slot_count,
  input  logic [wkm_pkg::CAP_W-1:0]  capacity_total,
  output logic                     fits
);
  import wkm_pkg::*;

  logic [CNT_W-1:0] ahead_cnt;
  logic [ACC_W-1:0] need_sum;

  // Clear at the start of a scan, add one ahead peer per step
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      ahead_cnt <= '0;
      need_sum  <= '0;
    end else if (ctl.add) begin
      ahead_cnt <= ahead_cnt + 1'b1;
      need_sum  <= need_sum + ACC_W'(ctl.need);
    end
  end

  // Free slot and room for our own amount
  assign fits = (SUM_W'(ahead_cnt) < SUM_W'(slot_count)) &&
                (SUM_W'(need_sum) + SUM_W'(own_need) <= SUM_W'(capacity_total));

endmodule

// File: test/tb_weighted_k_mutex_node.sv
// Testbench for weighted_k_mutex_node: directed and random lock events checked against a predictor.
`timescale 1ns / 100ps

module tb_weighted_k_mutex_node;
  import wkm_pkg::*;

  // One lock event as driven on the event channel
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [PEER_W-1:0]  peer_id;
    logic [STAMP_W-1:0] peer_stamp;
    logic [AMT_W-1:0]   peer_amount;
    logic [STAMP_W-1:0] peer_clock;
    logic [AMT_W-1:0]   own_amount;
  } lock_event_t;

  // One outgoing protocol message
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PEER_W-1:0]  dest;
    logic [STAMP_W-1:0] stamp;
    logic [AMT_W-1:0]   amount;
    logic [STAMP_W-1:0] msg_clock;
    logic               granted;
    logic               last;
  } lock_msg_t;

  logic clk;
  logic rst;

  wkm_cfg_if cfg_ch ();
  wkm_evt_if evt_ch ();
  wkm_msg_if msg_ch ();

  weighted_k_mutex_node dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .evt(evt_ch),
    .msg(msg_ch)
  );

  // Predicted node state
  logic [3:0]         reg_own_id;
  logic [4:0]         reg_nodes;
  logic [4:0]         reg_slots;
  logic [7:0]         reg_capacity;
  logic [STAMP_W-1:0] lam_clock;
  logic [STAMP_W-1:0] my_stamp;
  logic [AMT_W-1:0]   my_need;
  bit                 requesting;
  bit                 holding;
  logic [CLS_W-1:0]   peer_cls [MAX_NODES];
  logic [STAMP_W-1:0] peer_stamp_tab [MAX_NODES];
  logic [AMT_W-1:0]   peer_need_tab [MAX_NODES];

  lock_msg_t expected_msgs [$];
  lock_msg_t step_msgs [$];
  int        err_count;
  bit        idle_on;

  always #5 clk = ~clk;

  // Stop a hung run
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ERROR %s", $time, what);
    err_count++;
  endtask

  function automatic string msg_str(input lock_msg_t m);
    return $sformatf("kind=%0d dest=%0d stamp=%h amount=%0d clock=%h granted=%0b last=%0b",
                     m.kind, m.dest, m.stamp, m.amount, m.msg_clock, m.granted, m.last);
  endfunction

  function automatic int idle_cycles();
    return idle_on ? int'($urandom_range(0, 6)) : 0;
  endfunction

  function automatic lock_event_t mk_event(input logic [OP_W-1:0] op,
                                           input logic [PEER_W-1:0] peer,
                                           input logic [STAMP_W-1:0] stamp,
                                           input logic [AMT_W-1:0] amount,
                                           input logic [STAMP_W-1:0] pclock,
                                           input logic [AMT_W-1:0] own_amt);
    lock_event_t e;
    e.op = op;
    e.peer_id = peer;
    e.peer_stamp = stamp;
    e.peer_amount = amount;
    e.peer_clock = pclock;
    e.own_amount = own_amt;
    return e;
  endfunction

  // Advance the Lamport clock, holding at all ones
  task automatic tick_clock();
    if (lam_clock != {STAMP_W{1'b1}}) lam_clock = lam_clock + 1'b1;
  endtask

  task automatic merge_clock(input logic [STAMP_W-1:0] other);
    if (other > lam_clock) lam_clock = other;
    tick_clock();
  endtask

  task automatic add_msg(input logic [KIND_W-1:0] kind, input logic [PEER_W-1:0] dest,
                         input logic [STAMP_W-1:0] stamp, input logic [AMT_W-1:0] amount,
                         input logic [STAMP_W-1:0] mclock);
    lock_msg_t m;
    m.kind = kind;
    m.dest = dest;
    m.stamp = stamp;
    m.amount = amount;
    m.msg_clock = mclock;
    m.granted = 1'b0;
    m.last = 1'b0;
    step_msgs.push_back(m);
  endtask

  // Update the predicted node for one accepted event and queue its messages
  task automatic apply_lock_event(input lock_event_t e);
    int n;
    int ahead;
    int need_sum;
    bit peer_ok;
    bit we_lead;
    bit all_known;
    step_msgs.delete();
    n = (reg_nodes > 16) ? 16 : int'(reg_nodes);
    peer_ok = (int'(e.peer_id) < n) && (e.peer_id != reg_own_id);
    if (e.op == OP_PEER_REQ && peer_ok) begin
      // lower (stamp, id) wins; a node not asking always yields
      we_lead = requesting && ((my_stamp == e.peer_stamp) ? (reg_own_id < e.peer_id)
                                                          : (my_stamp < e.peer_stamp));
      if (!we_lead) begin
        tick_clock();
        add_msg(MSG_ACK, e.peer_id, e.peer_stamp, e.peer_amount, lam_clock);
        peer_cls[e.peer_id] = CLS_AHEAD;
      end else begin
        peer_cls[e.peer_id] = CLS_DEFER;
      end
      peer_stamp_tab[e.peer_id] = e.peer_stamp;
      peer_need_tab[e.peer_id] = e.peer_amount;
      merge_clock(e.peer_stamp);
    end else if (e.op == OP_PEER_ACK && peer_ok) begin
      if (peer_cls[e.peer_id] == CLS_AHEAD || peer_cls[e.peer_id] == CLS_NEUTRAL)
        peer_cls[e.peer_id] = CLS_UNKNOWN;
      // an ack for another stamp changes nothing more
      if (e.peer_stamp == my_stamp) begin
        if (peer_cls[e.peer_id] != CLS_DEFER) begin
          peer_cls[e.peer_id] = CLS_NEUTRAL;
          peer_stamp_tab[e.peer_id] = e.peer_stamp;
          peer_need_tab[e.peer_id] = e.peer_amount;
        end
        merge_clock(e.peer_clock);
      end
    end else if (e.op == OP_START && !requesting) begin
      tick_clock();
      my_stamp = lam_clock;
      my_need = e.own_amount;
      for (int i = 0; i < n; i++)
        if (i != reg_own_id && step_msgs.size() < 15)
          add_msg(MSG_REQ, PEER_W'(i), my_stamp, my_need, lam_clock);
      requesting = 1'b1;
    end else if (e.op == OP_RELEASE && holding) begin
      tick_clock();
      for (int i = 0; i < n; i++) begin
        if (peer_cls[i] == CLS_NEUTRAL) begin
          peer_cls[i] = CLS_UNKNOWN;
        end else if (peer_cls[i] == CLS_DEFER) begin
          if (i != reg_own_id && step_msgs.size() < 15)
            add_msg(MSG_ACK, PEER_W'(i), peer_stamp_tab[i], peer_need_tab[i], lam_clock);
          peer_cls[i] = CLS_AHEAD;
        end
      end
      requesting = 1'b0;
      holding = 1'b0;
    end
    // Grant once every peer is classified and the ahead set leaves room
    if (requesting && !holding) begin
      all_known = 1'b1;
      ahead = 0;
      need_sum = 0;
      for (int i = 0; i < n; i++) begin
        if (i != reg_own_id) begin
          if (peer_cls[i] == CLS_UNKNOWN) begin
            all_known = 1'b0;
          end else if (peer_cls[i] == CLS_AHEAD) begin
            ahead++;
            need_sum += peer_need_tab[i];
          end
        end
      end
      if (all_known && ahead < int'(reg_slots) && need_sum + int'(my_need) <= int'(reg_capacity))
        holding = 1'b1;
    end
    if (step_msgs.size() == 0) add_msg(MSG_NONE, '0, '0, '0, '0);
    foreach (step_msgs[j]) begin
      step_msgs[j].granted = holding;
      step_msgs[j].last = (j == step_msgs.size() - 1);
      expected_msgs.push_back(step_msgs[j]);
    end
  endtask

  // Build a random event, mostly a well-formed protocol step for the current state
  function automatic lock_event_t random_event();
    lock_event_t e;
    int n;
    int roll;
    logic [PEER_W-1:0] p;
    e.op = OP_W'($urandom_range(0, 3));
    e.peer_id = PEER_W'($urandom_range(0, 15));
    e.peer_stamp = $urandom;
    e.peer_amount = AMT_W'($urandom_range(0, 255));
    e.peer_clock = $urandom;
    e.own_amount = AMT_W'($urandom_range(1, 255));
    roll = $urandom_range(0, 99);
    if (roll < 10) return e;
    n = (reg_nodes > 16) ? 16 : int'(reg_nodes);
    // prefer a peer that still blocks the grant
    p = '0;
    for (int t = 0; t < 6; t++) begin
      p = PEER_W'($urandom_range(0, n - 1));
      if (p != reg_own_id && (!requesting || peer_cls[p] == CLS_UNKNOWN ||
                              peer_cls[p] == CLS_AHEAD))
        break;
    end
    e.peer_id = p;
    if ($urandom_range(0, 3) != 0) e.peer_amount = AMT_W'($urandom_range(0, reg_capacity / 4));
    if ($urandom_range(0, 7) != 0)
      e.own_amount = AMT_W'($urandom_range(1, (reg_capacity > 2) ? reg_capacity / 2 : 1));
    if ($urandom_range(0, 15) != 0) e.peer_clock = lam_clock + 32'($urandom_range(0, 10));
    roll = $urandom_range(0, 99);
    if (holding) begin
      e.op = (roll < 55) ? OP_RELEASE : OP_PEER_REQ;
      e.peer_stamp = lam_clock + 32'($urandom_range(0, 6)) - 32'd3;
    end else if (requesting) begin
      if (roll < 55) begin
        e.op = OP_PEER_ACK;
        e.peer_stamp = my_stamp;
      end else if (roll < 80) begin
        e.op = OP_PEER_REQ;
        e.peer_stamp = my_stamp + 32'($urandom_range(0, 4)) - 32'd2;
      end else begin
        e.op = OP_PEER_ACK;
        e.peer_stamp = my_stamp ^ (32'd1 << $urandom_range(0, 31));
      end
    end else begin
      e.op = (roll < 45) ? OP_START : OP_PEER_REQ;
      e.peer_stamp = lam_clock + 32'($urandom_range(0, 6)) - 32'd3;
    end
    return e;
  endfunction

  // Drive one request and hold it until accepted
  task automatic send_event(input lock_event_t e);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      evt_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    evt_ch.op = e.op;
    evt_ch.peer_id = e.peer_id;
    evt_ch.peer_stamp = e.peer_stamp;
    evt_ch.peer_amount = e.peer_amount;
    evt_ch.peer_clock = e.peer_clock;
    evt_ch.own_amount = e.own_amount;
    evt_ch.valid = 1'b1;
    do @(posedge clk); while (!evt_ch.ready);
    apply_lock_event(e);
    @(negedge clk);
  endtask

  // Hold the sender until every predicted message has come out
  task automatic wait_results_done();
    evt_ch.valid = 1'b0;
    while (expected_msgs.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.index = index;
    cfg_ch.data = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (index)
      CFG_OWN_ID:     reg_own_id = data[3:0];
      CFG_NODE_COUNT: reg_nodes = data[4:0];
      CFG_SLOT_COUNT: reg_slots = data[4:0];
      CFG_CAPACITY:   reg_capacity = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Reprogram all registers once the node is quiet
  task automatic configure_node(input int own, input int nodes, input int slots, input int cap);
    wait_results_done();
    write_reg(CFG_OWN_ID, CFG_DATA_W'(own));
    write_reg(CFG_NODE_COUNT, CFG_DATA_W'(nodes));
    write_reg(CFG_SLOT_COUNT, CFG_DATA_W'(slots));
    write_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
    cfg_ch.valid = 1'b0;
  endtask

  // Reset configuration: one full lock cycle with a single peer
  task automatic test_default_config();
    idle_on = 1'b1;
    send_event(mk_event(OP_START, 4'd0, 32'd0, 8'd0, 32'd0, 8'd1));
    send_event(mk_event(OP_PEER_ACK, 4'd1, my_stamp, 8'd0, 32'd0, 8'd1));
    send_event(mk_event(OP_RELEASE, 4'd0, 32'd0, 8'd0, 32'd0, 8'd1));
    send_event(mk_event(OP_PEER_REQ, 4'd1, lam_clock, 8'd1, 32'd0, 8'd1));
  endtask

  // Ignored events, stamp ties, stale and deferred acks, grant and blocked grant
  task automatic test_directed_cases();
    configure_node(2, 4, 2, 20);
    send_event(mk_event(OP_RELEASE, 4'd0, 32'd0, 8'd0, 32'd0, 8'd1));
    send_event(mk_event(OP_PEER_ACK, 4'd1, my_stamp + 32'd5, 8'd9, 32'hFFFF_FFFF, 8'd1));
    send_event(mk_event(OP_PEER_REQ, 4'd15, 32'hFFFF_FFFF, 8'd255, 32'd0, 8'd1));
    send_event(mk_event(OP_PEER_REQ, 4'd2, 32'd3, 8'd1, 32'd0, 8'd1));
    send_event(mk_event(OP_PEER_REQ, 4'd0, 32'd0, 8'd255, 32'd0, 8'd1));
    send_event(mk_event(OP_START, 4'd0, 32'd0, 8'd0, 32'd0, 8'd5));
    send_event(mk_event(OP_START, 4'd0, 32'd0, 8'd0, 32'd0, 8'd255));
    // equal stamps: the lower node id goes first
    send_event(mk_event(OP_PEER_REQ, 4'd1, my_stamp, 8'd3, 32'd0, 8'd1));
    send_event(mk_event(OP_PEER_REQ, 4'd3, my_stamp, 8'd4, 32'd0, 8'd1));
    send_event(mk_event(OP_PEER_ACK, 4'd0, my_stamp, 8'd0, 32'd0, 8'd1));
    send_event(mk_event(OP_PEER_ACK, 4'd3, my_stamp, 8'd6, lam_clock + 32'd7, 8'd1));
    send_event(mk_event(OP_PEER_ACK, 4'd1, my_stamp + 32'd1, 8'd2, 32'd0, 8'd1));
    send_event(mk_event(OP_PEER_ACK, 4'd1, my_stamp, 8'd7, lam_clock, 8'd1));
    send_event(mk_event(OP_PEER_REQ, 4'd0, my_stamp + 32'd100, 8'd200, 32'd0, 8'd1));
    send_event(mk_event(OP_RELEASE, 4'd0, 32'd0, 8'd0, 32'd0, 8'd1));
    // own need above capacity blocks the grant
    send_event(mk_event(OP_START, 4'd0, 32'd0, 8'd0, 32'd0, 8'd255));
    send_event(mk_event(OP_PEER_ACK, 4'd1, my_stamp, 8'd1, lam_clock, 8'd1));
    send_event(mk_event(OP_PEER_ACK, 4'd0, my_stamp, 8'd1, lam_clock, 8'd1));
    send_event(mk_event(OP_PEER_ACK, 4'd3, my_stamp, 8'd1, lam_clock, 8'd1));
  endtask

  // Random protocol traffic under one configuration
  task automatic test_random_traffic(input int own, input int nodes, input int slots,
                                     input int cap, input int count, input bit idle);
    configure_node(own, nodes, slots, cap);
    idle_on = idle;
    repeat (count) begin
      if ($urandom_range(0, 24) == 0) wait_results_done();
      send_event(random_event());
    end
  endtask

  // Drive the Lamport clock into saturation and keep running
  task automatic test_clock_saturation();
    configure_node(4, 3, 2, 255);
    idle_on = 1'b1;
    send_event(mk_event(OP_PEER_REQ, 4'd0, 32'hFFFF_FFFF, 8'd1, 32'd0, 8'd1));
    send_event(mk_event(OP_PEER_ACK, 4'd1, my_stamp, 8'd2, 32'hFFFF_FFFF, 8'd1));
    repeat (10) send_event(random_event());
  endtask

  // Accept messages with random stalls and compare against the oldest prediction
  initial begin
    lock_msg_t got;
    lock_msg_t exp_msg;
    int stall;
    msg_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        msg_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      msg_ch.ready = 1'b1;
      do @(posedge clk); while (msg_ch.valid !== 1'b1);
      got.kind = msg_ch.msg_kind;
      got.dest = msg_ch.dest_id;
      got.stamp = msg_ch.msg_stamp;
      got.amount = msg_ch.msg_amount;
      got.msg_clock = msg_ch.msg_clock;
      got.granted = msg_ch.granted;
      got.last = msg_ch.last;
      if (expected_msgs.size() == 0) begin
        report_mismatch($sformatf("unexpected message %s", msg_str(got)));
      end else begin
        exp_msg = expected_msgs.pop_front();
        if (got.kind !== exp_msg.kind || got.dest !== exp_msg.dest ||
            got.stamp !== exp_msg.stamp || got.amount !== exp_msg.amount ||
            got.msg_clock !== exp_msg.msg_clock || got.granted !== exp_msg.granted ||
            got.last !== exp_msg.last)
          report_mismatch($sformatf("got %s / want %s", msg_str(got), msg_str(exp_msg)));
      end
      @(negedge clk);
    end
  end

  // Reset, run every test, then settle and decide
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    evt_ch.valid = 1'b0;
    evt_ch.op = OP_PEER_REQ;
    evt_ch.peer_id = '0;
    evt_ch.peer_stamp = '0;
    evt_ch.peer_amount = '0;
    evt_ch.peer_clock = '0;
    evt_ch.own_amount = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_OWN_ID;
    cfg_ch.data = '0;
    reg_own_id = '0;
    reg_nodes = 5'd2;
    reg_slots = 5'd1;
    reg_capacity = 8'd1;
    lam_clock = '0;
    my_stamp = '0;
    my_need = '0;
    requesting = 1'b0;
    holding = 1'b0;
    foreach (peer_cls[i]) begin
      peer_cls[i] = CLS_UNKNOWN;
      peer_stamp_tab[i] = '0;
      peer_need_tab[i] = '0;
    end
    err_count = 0;
    idle_on = 1'b1;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_default_config();
    test_directed_cases();
    test_random_traffic(15, 16, 16, 255, 30, 1'b1);
    test_random_traffic(0, 2, 1, 1, 25, 1'b0);
    test_random_traffic(7, 16, 1, 255, 30, 1'b1);
    test_random_traffic(5, 3, 0, 100, 15, 1'b1);
    test_random_traffic(9, 4, 2, 30, 30, 1'b0);
    test_random_traffic(3, 9, 3, 255, 25, 1'b1);
    test_clock_saturation();

    wait_results_done();
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
sv/wkm_pkg.sv
sv/wkm_if.sv
sv/wkm_grant_acc.sv
sv/weighted_k_mutex_node.sv
test/tb_weighted_k_mutex_node.sv
